/* rtl/owm_pkg.sv */
// Package with the shared types and constants of the 1-Wire bus master.
`default_nettype none

package owm_pkg;

    localparam int TICK_W    = 10;
    localparam int BITS_W    = 4;
    localparam int BYTE_W    = 8;
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [TICK_W-1:0] RESET_RECOVERY_TICKS = 10'd410;
    localparam logic [BITS_W-1:0] MAX_BITS             = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ONE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ZERO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ZERO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_REC    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE    = 3'd7;

    // Reset values of the timing registers, highest index first.
    localparam logic [CFG_NUM-1:0][TICK_W-1:0] CFG_RESET = {
        10'd70, 10'd480, 10'd55, 10'd9, 10'd10, 10'd60, 10'd64, 10'd6
    };

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_RST_LOW   = 7'b0000010,
        PH_RST_WAIT1 = 7'b0000100,
        PH_RST_WAIT2 = 7'b0001000,
        PH_SLOT_LOW  = 7'b0010000,
        PH_SLOT_HIGH = 7'b0100000,
        PH_READ_REC  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              present;
        logic [BYTE_W-1:0] read_data;
        logic              rejected;
    } t_result;

endpackage

`default_nettype wire

/* rtl/onewire_bus_master_core.sv */
// 1-Wire bus master: command and tick processing with a registered result stage.
`default_nettype none

// The block takes one beat per clock cycle while its skid register is empty, commands and
// microsecond ticks alike, and returns exactly one registered result beat for each.
// The timing sequencer and the result register form a single pass, so a new beat can be
// taken in every cycle in which o_stall is low; phases of zero length are resolved within
// the same tick by a priority search over the remaining slot phases. A skid register behind
// the result register lets the input side take one more beat after the output side stalls.
module onewire_bus_master_core import owm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TICK_W-1:0]    i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_kind,
    input  wire logic [BYTE_W-1:0]    i_data_byte,
    input  wire logic [BITS_W-1:0]    i_bit_count,
    input  wire logic                 i_bus_level,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_drive_low,
    output logic                      o_busy_res,
    output logic                      o_done_res,
    output logic                      o_present,
    output logic [BYTE_W-1:0]         o_read_data,
    output logic                      o_rejected
);

    logic [TICK_W-1:0] r_cfg [CFG_NUM];

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [BITS_W-1:0] r_bits, n_bits;
    t_kind             r_op, n_op;
    logic              r_first, n_first;
    logic              r_present, n_present;
    logic [BYTE_W-1:0] r_last_read, n_last_read;

    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;
    logic    accept_in;
    logic    out_free;

    logic              wr_found;
    logic [3:0]        wr_pos;
    logic [TICK_W-1:0] wr_dur;

    logic              rd_found;
    logic [1:0]        rd_k;
    logic              rd_adv;
    logic              rd_samp;
    logic [TICK_W-1:0] rd_dur;
    logic [1:0]        rd_kcur;
    logic [BITS_W-1:0] rd_nfin;
    logic [BYTE_W-1:0] rd_fin_shift;

    t_kind kind;

    assign kind      = t_kind'(i_kind);
    assign o_stall   = r_skid_valid;
    assign accept_in = i_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || !i_stall;

    // Search for the first write slot phase of non-zero length after the current one.
    always_comb begin
        logic [4:0]        e;
        logic [4:0]        lim;
        logic [2:0]        idx;
        logic [TICK_W-1:0] d;
        wr_found = 1'b0;
        wr_pos   = '0;
        wr_dur   = '0;
        lim      = {r_bits, 1'b0};
        for (int j = 1; j < 16; j++) begin
            e   = 5'(j) + {4'd0, r_phase == PH_SLOT_HIGH};
            idx = e[3:1];
            if (r_shift[idx]) begin
                d = e[0] ? r_cfg[CFG_HIGH_ONE] : r_cfg[CFG_LOW_ONE];
            end else begin
                d = e[0] ? r_cfg[CFG_HIGH_ZERO] : r_cfg[CFG_LOW_ZERO];
            end
            if (!wr_found && (e < lim) && (d != '0)) begin
                wr_found = 1'b1;
                wr_pos   = e[3:0];
                wr_dur   = d;
            end
        end
    end

    // Read slots repeat the same three phases, so at most three positions need checking.
    always_comb begin
        logic [2:0]        pos;
        logic              adv;
        logic [1:0]        kn;
        logic              smp;
        logic [TICK_W-1:0] d;
        case (r_phase)
            PH_SLOT_HIGH: rd_kcur = 2'd1;
            PH_READ_REC:  rd_kcur = 2'd2;
            default:      rd_kcur = 2'd0;
        endcase
        rd_found = 1'b0;
        rd_k     = '0;
        rd_adv   = 1'b0;
        rd_samp  = 1'b0;
        rd_dur   = '0;
        for (int t = 1; t < 4; t++) begin
            pos = {1'b0, rd_kcur} + 3'(t);
            adv = pos >= 3'd3;
            kn  = adv ? 2'(pos - 3'd3) : pos[1:0];
            smp = ((rd_kcur <= 2'd1) && (pos >= 3'd2)) || (pos == 3'd5);
            case (kn)
                2'd0:    d = r_cfg[CFG_LOW_ONE];
                2'd1:    d = r_cfg[CFG_READ_SAMPLE];
                default: d = r_cfg[CFG_READ_REC];
            endcase
            if (!rd_found && (!adv || (r_bits > 4'd1)) && (d != '0)) begin
                rd_found = 1'b1;
                rd_k     = kn;
                rd_adv   = adv;
                rd_samp  = smp;
                rd_dur   = d;
            end
        end
        rd_nfin      = r_bits - {3'd0, rd_kcur == 2'd2};
        rd_fin_shift = (r_shift >> rd_nfin) | (i_bus_level ? ~(8'hFF >> rd_nfin) : 8'h00);
    end

    always_comb begin
        logic wait2;
        logic finish;
        logic [BITS_W-1:0] cnt;
        n_phase     = r_phase;
        n_count     = r_count;
        n_shift     = r_shift;
        n_bits      = r_bits;
        n_op        = r_op;
        n_first     = r_first;
        n_present   = r_present;
        n_last_read = r_last_read;
        n_res       = '0;
        wait2       = 1'b0;
        finish      = 1'b0;
        cnt         = (i_bit_count > MAX_BITS) ? MAX_BITS : i_bit_count;

        case (kind)
            KIND_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_count != '0) begin
                        n_count         = r_count - 10'd1;
                        n_res.drive_low = (r_phase == PH_RST_LOW) || (r_phase == PH_SLOT_LOW);
                    end else begin
                        case (r_phase)
                            PH_RST_LOW: begin
                                if (r_cfg[CFG_PRESENCE] != '0) begin
                                    n_phase = PH_RST_WAIT1;
                                    n_count = r_cfg[CFG_PRESENCE] - 10'd1;
                                end else begin
                                    n_first = i_bus_level;
                                    wait2   = 1'b1;
                                end
                            end
                            PH_RST_WAIT1: begin
                                n_first = i_bus_level;
                                wait2   = 1'b1;
                            end
                            PH_RST_WAIT2: begin
                                n_present = !r_first && i_bus_level;
                                finish    = 1'b1;
                            end
                            PH_SLOT_LOW, PH_SLOT_HIGH, PH_READ_REC: begin
                                if (r_op == KIND_READ) begin
                                    if (rd_found) begin
                                        case (rd_k)
                                            2'd0:    n_phase = PH_SLOT_LOW;
                                            2'd1:    n_phase = PH_SLOT_HIGH;
                                            default: n_phase = PH_READ_REC;
                                        endcase
                                        n_count = rd_dur - 10'd1;
                                        if (rd_samp) begin
                                            n_shift = {i_bus_level, r_shift[7:1]};
                                        end
                                        if (rd_adv) begin
                                            n_bits = r_bits - 4'd1;
                                        end
                                        n_res.drive_low = (rd_k == 2'd0);
                                    end else begin
                                        n_shift = rd_fin_shift;
                                        n_bits  = '0;
                                        finish  = 1'b1;
                                    end
                                end else begin
                                    if (wr_found) begin
                                        n_phase = wr_pos[0] ? PH_SLOT_HIGH : PH_SLOT_LOW;
                                        n_count = wr_dur - 10'd1;
                                        n_shift = r_shift >> wr_pos[3:1];
                                        n_bits  = r_bits - {1'b0, wr_pos[3:1]};
                                        n_res.drive_low = !wr_pos[0];
                                    end else begin
                                        n_shift = '0;
                                        n_bits  = '0;
                                        finish  = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                finish = 1'b1;
                            end
                        endcase
                        if (wait2) begin
                            if (RESET_RECOVERY_TICKS != '0) begin
                                n_phase = PH_RST_WAIT2;
                                n_count = RESET_RECOVERY_TICKS - 10'd1;
                            end else begin
                                n_present = 1'b0;
                                finish    = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_RESET, KIND_WRITE, KIND_READ: begin
                if (r_phase != PH_IDLE) begin
                    n_res.rejected  = 1'b1;
                    n_res.drive_low = (r_phase == PH_RST_LOW) || (r_phase == PH_SLOT_LOW);
                end else begin
                    n_op = kind;
                    if (kind == KIND_RESET) begin
                        n_phase         = PH_RST_LOW;
                        n_count         = r_cfg[CFG_RESET_LOW];
                        n_res.drive_low = 1'b1;
                    end else begin
                        n_shift = (kind == KIND_WRITE) ? i_data_byte : '0;
                        n_bits  = cnt;
                        if (cnt == '0) begin
                            finish = 1'b1;
                        end else begin
                            n_phase = PH_SLOT_LOW;
                            if ((kind == KIND_READ) || i_data_byte[0]) begin
                                n_count = r_cfg[CFG_LOW_ONE];
                            end else begin
                                n_count = r_cfg[CFG_LOW_ZERO];
                            end
                            n_res.drive_low = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_res = '0;
            end
        endcase

        if (finish) begin
            n_phase         = PH_IDLE;
            n_count         = '0;
            n_res.done_res  = 1'b1;
            n_res.drive_low = 1'b0;
            if (n_op == KIND_READ) begin
                n_last_read = n_shift;
            end
        end

        n_res.busy_res  = (n_phase != PH_IDLE);
        n_res.present   = n_present;
        n_res.read_data = n_last_read;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_op        <= KIND_TICK;
            r_first     <= 1'b0;
            r_present   <= 1'b0;
            r_last_read <= '0;
        end else if (accept_in) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_shift     <= n_shift;
            r_bits      <= n_bits;
            r_op        <= n_op;
            r_first     <= n_first;
            r_present   <= n_present;
            r_last_read <= n_last_read;
        end
    end

    // The result register takes a new beat when free; otherwise the skid register holds it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || accept_in;
            r_skid_valid <= 1'b0;
        end else if (accept_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (accept_in) begin
            r_skid <= n_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_drive_low = r_out.drive_low;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_present   = r_out.present;
    assign o_read_data = r_out.read_data;
    assign o_rejected  = r_out.rejected;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the result register is empty");

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register lost its one-hot code");

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_count == '0))
        else $error("tick counter not cleared while idle");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_done_res && o_busy_res))
        else $error("result reports completion while still busy");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> (o_busy_res && !o_done_res))
        else $error("rejected command reported without a running operation");

endmodule

`default_nettype wire

/* verif/tb_onewire_bus_master_core.sv */
// Self-checking testbench for the 1-Wire bus master core with a cycle-free sequence predictor.
module tb_onewire_bus_master_core;
    import owm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 48;
    localparam int DRAIN_CYCLES    = 4;
    localparam int REPORT_CAP      = 200;
    localparam int PHASE_ITEMS     = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TICK_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_kind;
    logic [BYTE_W-1:0]    i_data_byte;
    logic [BITS_W-1:0]    i_bit_count;
    logic                 i_bus_level;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_drive_low;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic                 o_present;
    logic [BYTE_W-1:0]    o_read_data;
    logic                 o_rejected;

    onewire_bus_master_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_bit_count (i_bit_count),
        .i_bus_level (i_bus_level),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_drive_low (o_drive_low),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_present   (o_present),
        .o_read_data (o_read_data),
        .o_rejected  (o_rejected)
    );

    // Predicted sequencer state and timing registers.
    t_phase            seq_phase;
    logic [TICK_W-1:0] seq_ticks;
    logic [BYTE_W-1:0] seq_shift;
    logic [BITS_W-1:0] seq_bits;
    t_kind             seq_op;
    logic              seq_first;
    logic              seq_present;
    logic [BYTE_W-1:0] seq_read_byte;
    logic              seq_done;
    logic [TICK_W-1:0] bus_timing [CFG_NUM];

    t_result pending_results [$];
    int      mismatches    = 0;
    int      work_items    = 0;
    bit      sender_idle   = 1'b1;
    bit      receiver_idle = 1'b1;
    bit      hold_off_req  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic seq_drives();
        return (seq_phase == PH_RST_LOW) || (seq_phase == PH_SLOT_LOW);
    endfunction

    function automatic void close_operation();
        if (seq_op == KIND_READ) begin
            seq_read_byte = seq_shift;
        end
        seq_phase = PH_IDLE;
        seq_ticks = '0;
        seq_done  = 1'b1;
    endfunction

    function automatic void open_slot();
        if (seq_bits == '0) begin
            close_operation();
        end else begin
            seq_phase = PH_SLOT_LOW;
            if (seq_op == KIND_READ || seq_shift[0]) begin
                seq_ticks = bus_timing[CFG_LOW_ONE];
            end else begin
                seq_ticks = bus_timing[CFG_LOW_ZERO];
            end
        end
    endfunction

    function automatic void advance_phase(input logic level);
        case (seq_phase)
            PH_RST_LOW: begin
                seq_phase = PH_RST_WAIT1;
                seq_ticks = bus_timing[CFG_PRESENCE];
            end
            PH_RST_WAIT1: begin
                seq_first = level;
                seq_phase = PH_RST_WAIT2;
                seq_ticks = RESET_RECOVERY_TICKS;
            end
            PH_RST_WAIT2: begin
                seq_present = !seq_first && level;
                close_operation();
            end
            PH_SLOT_LOW: begin
                seq_phase = PH_SLOT_HIGH;
                if (seq_op == KIND_READ) begin
                    seq_ticks = bus_timing[CFG_READ_SAMPLE];
                end else if (seq_shift[0]) begin
                    seq_ticks = bus_timing[CFG_HIGH_ONE];
                end else begin
                    seq_ticks = bus_timing[CFG_HIGH_ZERO];
                end
            end
            PH_SLOT_HIGH: begin
                if (seq_op == KIND_READ) begin
                    seq_shift = {level, seq_shift[BYTE_W-1:1]};
                    seq_phase = PH_READ_REC;
                    seq_ticks = bus_timing[CFG_READ_REC];
                end else begin
                    seq_shift = seq_shift >> 1;
                    seq_bits  = seq_bits - 4'd1;
                    open_slot();
                end
            end
            PH_READ_REC: begin
                seq_bits = seq_bits - 4'd1;
                open_slot();
            end
            default: begin
                seq_phase = PH_IDLE;
                seq_ticks = '0;
            end
        endcase
    endfunction

    function automatic t_result predict_bus_master(input t_kind kind,
                                                   input logic [BYTE_W-1:0] data,
                                                   input logic [BITS_W-1:0] count,
                                                   input logic level);
        t_result res;
        logic    drive;
        logic    reject;
        logic    waiting;
        drive    = 1'b0;
        reject   = 1'b0;
        seq_done = 1'b0;
        if (kind == KIND_TICK) begin
            waiting = 1'b1;
            while (seq_phase != PH_IDLE && waiting) begin
                if (seq_ticks != '0) begin
                    seq_ticks = seq_ticks - 10'd1;
                    drive     = seq_drives();
                    waiting   = 1'b0;
                end else begin
                    advance_phase(level);
                end
            end
        end else if (seq_phase != PH_IDLE) begin
            reject = 1'b1;
            drive  = seq_drives();
        end else begin
            seq_op = kind;
            if (kind == KIND_RESET) begin
                seq_phase = PH_RST_LOW;
                seq_ticks = bus_timing[CFG_RESET_LOW];
            end else begin
                seq_shift = (kind == KIND_WRITE) ? data : '0;
                seq_bits  = (count > MAX_BITS) ? MAX_BITS : count;
                open_slot();
            end
            drive = seq_drives();
        end
        res.drive_low = drive;
        res.busy_res  = (seq_phase != PH_IDLE);
        res.done_res  = seq_done;
        res.present   = seq_present;
        res.read_data = seq_read_byte;
        res.rejected  = reject;
        return res;
    endfunction

    function automatic logic [BITS_W-1:0] rand_count();
        if ($urandom_range(0, 4) == 0) begin
            return BITS_W'($urandom_range(0, 15));
        end
        return BITS_W'($urandom_range(1, 8));
    endfunction

    task automatic send_item(input t_kind kind, input logic [BYTE_W-1:0] data,
                             input logic [BITS_W-1:0] count, input logic level);
        t_result res;
        logic    was_busy;
        int      gap;
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= data;
        i_bit_count <= count;
        i_bus_level <= level;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        was_busy = (seq_phase != PH_IDLE);
        res = predict_bus_master(kind, data, count, level);
        pending_results.push_back(res);
        if (!res.rejected && (kind != KIND_TICK || was_busy)) begin
            work_items++;
        end
    endtask

    // Ticks with random line levels until the operation ends, with the odd command thrown in
    // while busy.
    task automatic tick_until_idle();
        while (seq_phase != PH_IDLE) begin
            if ($urandom_range(0, 24) == 0) begin
                send_item(t_kind'($urandom_range(1, 3)), BYTE_W'($urandom), rand_count(),
                          1'($urandom));
            end else begin
                send_item(KIND_TICK, BYTE_W'($urandom), BITS_W'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic run_command(input t_kind kind, input logic [BYTE_W-1:0] data,
                               input logic [BITS_W-1:0] count);
        send_item(kind, data, count, 1'($urandom));
        tick_until_idle();
    endtask

    task automatic run_random_operation();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            run_command(KIND_RESET, BYTE_W'($urandom), rand_count());
        end else if (pick < 50) begin
            run_command(KIND_WRITE, BYTE_W'($urandom), rand_count());
        end else if (pick < 90) begin
            run_command(KIND_READ, BYTE_W'($urandom), rand_count());
        end else begin
            send_item(KIND_TICK, BYTE_W'($urandom), BITS_W'($urandom), 1'($urandom));
        end
    endtask

    task automatic settle_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timing_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [TICK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        bus_timing[idx] = value;
    endtask

    task automatic load_uniform_timing(input logic [TICK_W-1:0] value);
        settle_block();
        for (int r = 0; r < CFG_NUM; r++) begin
            write_timing_reg(CFG_IDX_W'(r), value);
        end
    endtask

    task automatic load_random_timing();
        settle_block();
        for (int r = 0; r < CFG_NUM; r++) begin
            if ($urandom_range(0, 5) == 0) begin
                write_timing_reg(CFG_IDX_W'(r), TICK_W'($urandom_range(0, 12)));
            end else begin
                write_timing_reg(CFG_IDX_W'(r), TICK_W'($urandom_range(0, 3)));
            end
        end
    endtask

    task automatic test_idle_and_rejection();
        send_item(KIND_TICK, 8'h00, 4'h0, 1'b0);
        send_item(KIND_TICK, 8'hFF, 4'hF, 1'b1);
        send_item(KIND_WRITE, 8'hFF, 4'd0, 1'b0);
        send_item(KIND_READ, 8'hFF, 4'd0, 1'b1);
        send_item(KIND_WRITE, 8'h00, 4'd1, 1'b0);
        send_item(KIND_RESET, 8'hFF, 4'd8, 1'b1);
        send_item(KIND_READ, 8'h00, 4'd15, 1'b0);
        send_item(KIND_WRITE, 8'hAA, 4'd3, 1'b1);
        tick_until_idle();
        run_command(KIND_READ, 8'h00, 4'd1);
    endtask

    task automatic test_zero_timing();
        load_uniform_timing('0);
        send_item(KIND_RESET, 8'h00, 4'd0, 1'b1);
        send_item(KIND_TICK, 8'hFF, 4'hF, 1'b0);
        while (seq_phase != PH_IDLE) begin
            send_item(KIND_TICK, 8'h00, 4'h0, 1'b1);
        end
        run_command(KIND_WRITE, 8'hFF, 4'd8);
        run_command(KIND_READ, 8'h00, 4'd12);
        run_command(KIND_WRITE, 8'h5A, 4'd15);
        run_command(KIND_RESET, 8'h00, 4'd1);
    endtask

    task automatic test_max_timing();
        load_uniform_timing('0);
        write_timing_reg(CFG_LOW_ONE, '1);
        run_command(KIND_WRITE, 8'h01, 4'd1);
    endtask

    task automatic test_random_traffic();
        int phase_end;
        for (int p = 0; p < 6; p++) begin
            load_random_timing();
            sender_idle   = (p != 0);
            receiver_idle = (p != 1);
            phase_end = work_items + PHASE_ITEMS;
            while (work_items < phase_end) begin
                run_random_operation();
            end
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // The sender keeps offering beats while the receiver holds off, so the block fills up.
    task automatic test_receiver_hold_off();
        load_uniform_timing(TICK_W'(2));
        sender_idle  = 1'b0;
        hold_off_req = 1'b1;
        run_command(KIND_WRITE, BYTE_W'($urandom), 4'd8);
        run_command(KIND_READ, BYTE_W'($urandom), 4'd8);
        sender_idle = 1'b1;
    endtask

    task automatic test_full_rate();
        load_random_timing();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        repeat (12) run_random_operation();
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                               input logic [BYTE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            if (mismatches < REPORT_CAP) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            end
            mismatches++;
        end
    endtask

    initial begin : result_stall_gen
        int burst;
        burst   = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                burst = HOLD_OFF_CYCLES;
            end else if (burst == 0 && receiver_idle && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 6);
            end
            if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : result_checker
        t_result exp_res;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (pending_results.size() == 0) begin
                    if (mismatches < REPORT_CAP) begin
                        $error("result beat arrived with no expectation pending");
                    end
                    mismatches++;
                end else begin
                    exp_res = pending_results.pop_front();
                    check_field("drive_low", BYTE_W'(exp_res.drive_low), BYTE_W'(o_drive_low));
                    check_field("busy_res", BYTE_W'(exp_res.busy_res), BYTE_W'(o_busy_res));
                    check_field("done_res", BYTE_W'(exp_res.done_res), BYTE_W'(o_done_res));
                    check_field("present", BYTE_W'(exp_res.present), BYTE_W'(o_present));
                    check_field("read_data", exp_res.read_data, o_read_data);
                    check_field("rejected", BYTE_W'(exp_res.rejected), BYTE_W'(o_rejected));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_kind      = KIND_TICK;
        i_data_byte = '0;
        i_bit_count = '0;
        i_bus_level = 1'b0;

        bus_timing[CFG_LOW_ONE]     = 10'd6;
        bus_timing[CFG_HIGH_ONE]    = 10'd64;
        bus_timing[CFG_LOW_ZERO]    = 10'd60;
        bus_timing[CFG_HIGH_ZERO]   = 10'd10;
        bus_timing[CFG_READ_SAMPLE] = 10'd9;
        bus_timing[CFG_READ_REC]    = 10'd55;
        bus_timing[CFG_RESET_LOW]   = 10'd480;
        bus_timing[CFG_PRESENCE]    = 10'd70;
        seq_phase     = PH_IDLE;
        seq_ticks     = '0;
        seq_shift     = '0;
        seq_bits      = '0;
        seq_op        = KIND_TICK;
        seq_first     = 1'b0;
        seq_present   = 1'b0;
        seq_read_byte = '0;
        seq_done      = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_rejection();
        test_zero_timing();
        test_max_timing();
        test_random_traffic();
        test_receiver_hold_off();
        test_full_rate();

        settle_block();
        if (pending_results.size() != 0) begin
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
